// ===== design/edfts_pkg.sv =====
// Shared constants for the EDF task selector.
`default_nettype none
package edfts_pkg;

  localparam int ALIVE_W       = 8;
  localparam int CHOSEN_W      = 3;
  localparam int SETTING_W     = 21;
  localparam int PERIOD_W      = 20;
  localparam int FREQ_BIT      = 20;
  localparam int CFG_INDEX_W   = 4;
  localparam int MAX_CFG_TASKS = 8;

  localparam logic [SETTING_W-1:0] SETTING_RESET = 21'd1148576;
  localparam logic [PERIOD_W-1:0]  RESET_PERIOD  = SETTING_RESET[PERIOD_W-1:0];

endpackage
`default_nettype wire

// ===== design/edfts_argmin.sv =====
// Registered-free comparator tree: earliest-deadline alive task, lowest index on ties.
`default_nettype none
module edfts_argmin #(
  parameter int NT = 8,
  parameter int DB = 48,
  parameter int TW = 3
) (
  input  wire logic [NT-1:0]         alive,
  input  wire logic [NT-1:0][DB-1:0] deadline,
  output logic                       found,
  output logic [TW-1:0]              idx
);
  localparam int P = 1 << TW;

  logic [P-1:0]  alive_pad;
  logic          nv [1:2*P-1];
  logic [DB-1:0] nd [1:2*P-1];
  logic [TW-1:0] ni [1:2*P-1];

  assign alive_pad = P'(alive);

  always_comb begin
    for (int i = 0; i < P; i++) begin
      nv[P+i] = alive_pad[i];
      ni[P+i] = TW'(i);
      nd[P+i] = '0;
      if (i < NT) begin
        nd[P+i] = deadline[i];
      end
    end
    for (int k = P - 1; k >= 1; k--) begin
      if (nv[2*k+1] && (!nv[2*k] || (nd[2*k+1] < nd[2*k]))) begin
        nv[k] = 1'b1;
        nd[k] = nd[2*k+1];
        ni[k] = ni[2*k+1];
      end else begin
        nv[k] = nv[2*k];
        nd[k] = nd[2*k];
        ni[k] = ni[2*k];
      end
    end
  end

  assign found = nv[1];
  assign idx   = ni[1];

endmodule
`default_nettype wire

// ===== design/edfts_preempt.sv =====
// Preemption search: lowest newly alive task with a deadline earlier than the current one.
`default_nettype none
module edfts_preempt #(
  parameter int NT = 8,
  parameter int DB = 48,
  parameter int TW = 3
) (
  input  wire logic [NT-1:0]         alive,
  input  wire logic [NT-1:0]         prior,
  input  wire logic [NT-1:0][DB-1:0] deadline,
  input  wire logic [TW-1:0]         cur,
  output logic                       hit,
  output logic [TW-1:0]              idx
);
  logic [DB-1:0] cur_dl;
  logic [NT-1:0] cand;

  assign cur_dl = deadline[cur];

  always_comb begin
    for (int i = 0; i < NT; i++) begin
      cand[i] = !prior[i] && alive[i] && (deadline[i] < cur_dl);
    end
  end

  always_comb begin
    idx = '0;
    for (int i = NT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        idx = TW'(i);
      end
    end
  end

  assign hit = |cand;

endmodule
`default_nettype wire

// ===== design/edf_task_selector_unit.sv =====
// EDF task selector top level: settings, deadline state, input and result registers.
// Usage:
//   Input channel (in_valid / in_stall / in_alive_mask) carries one alive mask per beat.
//   Result channel (out_valid / out_stall / out_*) returns one beat per input beat,
//   in order: chosen task, its frequency bit and a none-alive flag.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes task
//   settings; cfg_ready is always high, indexes at or above the task count are dropped.
//   Write settings only while no beat is in flight.
// Timing:
//   An accepted beat is held in the input register, then moves to the result register once
//   that is free; out_valid shows the result register. A beat is taken every cycle while
//   in_stall is low; the decision logic (one deadline add feeding one comparator tree over
//   the deadlines, one preemption compare per task) sits between the input register and
//   the result register.
// Reset (synchronous, rst_n low): settings return to period 100000 with the
//   frequency bit set, deadlines to that period, no prior selection, prior
//   alive mask all ones, both registers empty.
// Stall: a stalled result holds; the input register still takes one more beat if empty,
//   then in_stall rises until the result is taken.
`default_nettype none
module edf_task_selector_unit #(
  parameter int TASK_COUNT    = 8,
  parameter int DEADLINE_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [edfts_pkg::ALIVE_W-1:0]     in_alive_mask,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [edfts_pkg::CHOSEN_W-1:0]         out_chosen_task,
  output logic                                   out_high_freq,
  output logic                                   out_none_alive,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [edfts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [edfts_pkg::SETTING_W-1:0]   cfg_data
);
  import edfts_pkg::*;

  localparam int NT = (TASK_COUNT < MAX_CFG_TASKS) ? TASK_COUNT : MAX_CFG_TASKS;
  localparam int TW = $clog2(NT);
  localparam int DB = DEADLINE_BITS;

  logic [NT-1:0][SETTING_W-1:0] set_r;
  logic [NT-1:0][DB-1:0]        dl_r;
  logic [TW-1:0]                last_r;
  logic                         have_r;
  logic [NT-1:0]                prior_r;

  logic                         in_vld_r;
  logic [NT-1:0]                alive_r;
  logic                         out_vld_r;
  logic [CHOSEN_W-1:0]          chosen_r;
  logic                         hf_r;
  logic                         none_r;

  logic                         out_take;
  logic                         fire;
  logic                         in_acc;
  logic                         cfg_hit;

  logic                         finished;
  logic                         fresh;
  logic                         min_found;
  logic [TW-1:0]                min_idx;
  logic                         pre_hit;
  logic [TW-1:0]                pre_idx;
  logic [TW-1:0]                last_nxt;
  logic                         have_nxt;
  logic [DB-1:0]                dl_nxt;
  logic [NT-1:0][DB-1:0]        dl_eff;

  // handshake
  assign out_take  = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && out_take;
  assign in_stall  = in_vld_r && !out_take;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < CFG_INDEX_W'(NT));

  // fresh pick sees the finished task's advanced deadline
  always_comb begin
    dl_eff = dl_r;
    if (finished) begin
      dl_eff[last_r] = dl_nxt;
    end
  end

  edfts_argmin #(.NT(NT), .DB(DB), .TW(TW)) u_argmin (
    .alive    (alive_r),
    .deadline (dl_eff),
    .found    (min_found),
    .idx      (min_idx)
  );

  edfts_preempt #(.NT(NT), .DB(DB), .TW(TW)) u_preempt (
    .alive    (alive_r),
    .prior    (prior_r),
    .deadline (dl_r),
    .cur      (last_r),
    .hit      (pre_hit),
    .idx      (pre_idx)
  );

  // decision
  assign finished = have_r && prior_r[last_r] && !alive_r[last_r];
  assign fresh    = !have_r || finished;
  assign have_nxt = have_r || (fresh && min_found);
  assign dl_nxt   = dl_r[last_r] + DB'(set_r[last_r][PERIOD_W-1:0]);

  always_comb begin
    last_nxt = last_r;
    if (fresh) begin
      if (min_found) begin
        last_nxt = min_idx;
      end
    end else if (pre_hit) begin
      last_nxt = pre_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        set_r[i] <= SETTING_RESET;
      end
    end else if (cfg_hit) begin
      set_r[cfg_index[TW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        dl_r[i] <= DB'(RESET_PERIOD);
      end
      last_r  <= '0;
      have_r  <= 1'b0;
      prior_r <= '1;
    end else if (fire) begin
      if (finished) begin
        dl_r[last_r] <= dl_nxt;
      end
      last_r  <= last_nxt;
      have_r  <= have_nxt;
      prior_r <= alive_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      alive_r <= in_alive_mask[NT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      chosen_r <= CHOSEN_W'(last_nxt);
      hf_r     <= set_r[last_nxt][FREQ_BIT];
      none_r   <= (alive_r == '0);
    end
  end

  assign out_valid       = out_vld_r;
  assign out_chosen_task = chosen_r;
  assign out_high_freq   = hf_r;
  assign out_none_alive  = none_r;

endmodule
`default_nettype wire

// ===== test/edf_task_selector_checker.sv =====
// Checker for edf_task_selector_unit: shadows settings and deadlines, predicts each result beat.
module edf_task_selector_checker
  import edfts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [ALIVE_W-1:0]     in_alive_mask,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [CHOSEN_W-1:0]    out_chosen_task,
  input  logic                   out_high_freq,
  input  logic                   out_none_alive,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SETTING_W-1:0]   cfg_data,
  output int                     mismatches,
  output int                     backlog
);

  localparam int NT   = 8;
  localparam int DL_W = 48;

  typedef struct packed {
    logic [CHOSEN_W-1:0] chosen;
    logic                high_freq;
    logic                none_alive;
  } decision_t;

  logic [SETTING_W-1:0] setting [NT];
  logic [DL_W-1:0]      deadline [NT];
  logic [CHOSEN_W-1:0]  last_pick;
  logic                 have_pick;
  logic [ALIVE_W-1:0]   prev_alive;
  decision_t            decisions_due [$];

  initial begin
    mismatches = 0;
    backlog    = 0;
  end

  task automatic report(input string what, input int exp_val, input int got_val);
    $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  function automatic decision_t schedule(input logic [ALIVE_W-1:0] alive);
    logic [CHOSEN_W-1:0] cur;
    logic [CHOSEN_W-1:0] pick;
    logic                fresh;
    logic                hit;
    logic [DL_W-1:0]     best;
    decision_t           d;
    cur   = last_pick;
    pick  = cur;
    fresh = 1'b0;
    hit   = 1'b0;
    best  = '0;
    if (!have_pick) begin
      fresh = 1'b1;
    end else if (prev_alive[cur] && !alive[cur]) begin
      // current task finished: push its deadline out by one period
      deadline[cur] = deadline[cur] + DL_W'(setting[cur][PERIOD_W-1:0]);
      fresh = 1'b1;
    end else begin
      for (int i = 0; i < NT; i++) begin
        if (!hit && !prev_alive[i] && alive[i] && deadline[i] < deadline[cur]) begin
          pick = CHOSEN_W'(i);
          hit  = 1'b1;
        end
      end
    end
    if (fresh) begin
      hit = 1'b0;
      for (int i = 0; i < NT; i++) begin
        if (alive[i] && (!hit || deadline[i] < best)) begin
          best = deadline[i];
          pick = CHOSEN_W'(i);
          hit  = 1'b1;
        end
      end
      if (hit) have_pick = 1'b1;
    end
    last_pick    = pick;
    prev_alive   = alive;
    d.chosen     = pick;
    d.high_freq  = setting[pick][FREQ_BIT];
    d.none_alive = (alive == '0);
    return d;
  endfunction

  always @(posedge clk) begin
    decision_t want;
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        setting[i]  = SETTING_RESET;
        deadline[i] = DL_W'(RESET_PERIOD);
      end
      last_pick  = '0;
      have_pick  = 1'b0;
      prev_alive = '1;
      decisions_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (decisions_due.size() == 0) begin
          report("result beat with nothing pending", 0, 1);
        end else begin
          want = decisions_due.pop_front();
          if (out_chosen_task !== want.chosen)
            report("chosen_task", want.chosen, out_chosen_task);
          if (out_high_freq !== want.high_freq)
            report("high_freq", want.high_freq, out_high_freq);
          if (out_none_alive !== want.none_alive)
            report("none_alive", want.none_alive, out_none_alive);
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < MAX_CFG_TASKS)
        setting[cfg_index[2:0]] = cfg_data;
      if (in_valid && !in_stall)
        decisions_due.push_back(schedule(in_alive_mask));
    end
    backlog <= decisions_due.size();
  end

endmodule

// ===== test/edf_task_selector_unit_test.sv =====
// Testbench top for edf_task_selector_unit: clock, reset, stimulus, settings phases, verdict.
module edf_task_selector_unit_test;
  import edfts_pkg::*;

  localparam int PHASES     = 5;
  localparam int PHASE_BEATS = 205;
  localparam logic [ALIVE_W-1:0] OPENING [23] = '{
    8'h00, 8'hFF, 8'hFE, 8'hFC, 8'hFD, 8'h00, 8'h01, 8'h80, 8'h81, 8'h7F, 8'h40, 8'h20,
    8'h10, 8'h08, 8'h04, 8'h02, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h3C
  };
  localparam logic [SETTING_W-1:0] EDGE_SETTINGS [8] = '{
    21'h000000, 21'h1FFFFF, 21'h0FFFFF, 21'h100001,
    21'h100000, 21'h000001, 21'h1FFFFE, 21'h0AAAAA
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic [ALIVE_W-1:0]     in_alive_mask = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [SETTING_W-1:0]   cfg_data = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic [CHOSEN_W-1:0]    out_chosen_task;
  logic                   out_high_freq;
  logic                   out_none_alive;
  logic                   cfg_ready;
  int                     mismatches;
  int                     backlog;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  edf_task_selector_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_alive_mask,
    .out_valid, .out_stall, .out_chosen_task, .out_high_freq, .out_none_alive,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  edf_task_selector_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_alive_mask,
    .out_valid, .out_stall, .out_chosen_task, .out_high_freq, .out_none_alive,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .backlog
  );

  initial begin
    #1000000;
    $display("edf_task_selector_unit regression: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 80;
        out_stall = 1'b1;
      end else begin
        out_stall = !calm && ($urandom_range(99) < 36);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_mask(input logic [ALIVE_W-1:0] m);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_alive_mask = m;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (backlog != 0) @(negedge clk);
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [SETTING_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_phase(input int ph);
    logic [SETTING_W-1:0] val;
    drain();
    repeat (4) @(negedge clk);
    for (int i = 0; i < 8; i++) begin
      if (ph == 0) begin
        val = EDGE_SETTINGS[i];
      end else if ($urandom_range(3) != 0) begin
        // short periods keep deadlines close, so ties and preemptions show up
        val = {1'($urandom), 20'($urandom_range(16))};
      end else begin
        val = SETTING_W'($urandom);
      end
      write_setting(CFG_INDEX_W'(i), val);
    end
    write_setting(CFG_INDEX_W'(ph == 0 ? 15 : $urandom_range(8, 15)), SETTING_W'($urandom));
    cfg_valid = 1'b0;
  endtask

  function automatic logic [ALIVE_W-1:0] next_mask(input logic [ALIVE_W-1:0] prev);
    logic [ALIVE_W-1:0] m;
    int r;
    m = prev;
    r = $urandom_range(99);
    if (r < 50) begin
      m[$urandom_range(7)] ^= 1'b1;
      if ($urandom_range(1) == 1) m[$urandom_range(7)] ^= 1'b1;
    end else if (r < 80) begin
      m = ALIVE_W'($urandom);
    end else if (r < 88) begin
      m = '0;
    end else if (r < 95) begin
      m = ALIVE_W'(1 << $urandom_range(7));
    end else begin
      m = '1;
    end
    return m;
  endfunction

  initial begin
    logic [ALIVE_W-1:0] mask;
    mask = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    foreach (OPENING[k]) send_mask(OPENING[k]);
    for (int ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      calm = (ph == 3);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (ph == 1 && k == 60) hold_req = 1'b1;
        if (ph == 2 && k == 100) drain();
        if (ph == 3 && k == 90) calm = 1'b0;
        mask = next_mask(mask);
        send_mask(mask);
      end
    end
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("edf_task_selector_unit regression: pass");
    end else begin
      $display("edf_task_selector_unit regression: fail");
    end
    $finish;
  end

endmodule
